// ----- src/png_scanline_unfilter_unit_assert.svh -----
// Assertion macros shared by the checker files.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define SUNF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define SUNF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/sunf_pkg.sv -----
// Shared constants, types and the Paeth predictor for the scanline unfilter.
// No dependencies.
`default_nettype none

package sunf_pkg;

    localparam int MaxLineBytes  = 16384;
    localparam int MaxPixelBytes = 8;

    localparam int ByteW = 8;
    localparam int BppW  = 4;
    localparam int LineW = 15;

    localparam logic [BppW-1:0]  BppReset  = 4'd4;
    localparam logic [LineW-1:0] LineReset = 15'd1024;

    // Configuration register indexes
    localparam logic [0:0] CFG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [0:0] CFG_LINE_BYTES      = 1'b1;

    // Filter type codes
    localparam logic [7:0] FILT_NONE  = 8'd0;
    localparam logic [7:0] FILT_SUB   = 8'd1;
    localparam logic [7:0] FILT_UP    = 8'd2;
    localparam logic [7:0] FILT_AVG   = 8'd3;
    localparam logic [7:0] FILT_PAETH = 8'd4;

    // One stream byte as it leaves the front end
    typedef struct packed {
        logic             is_type;
        logic             first_row;
        logic             eol;
        logic [ByteW-1:0] fbyte;
        logic [ByteW-1:0] ftype;
    } t_item;

    // Paeth predictor, signed distances
    function automatic logic [ByteW-1:0] paeth_pick(input logic [ByteW-1:0] a,
                                                    input logic [ByteW-1:0] b,
                                                    input logic [ByteW-1:0] c);
        logic signed [9:0] sa;
        logic signed [9:0] sb;
        logic signed [9:0] sc;
        logic signed [9:0] p;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        sa = signed'({2'b00, a});
        sb = signed'({2'b00, b});
        sc = signed'({2'b00, c});
        p  = sa + sb - sc;
        da = p - sa;
        db = p - sb;
        dc = p - sc;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- src/sunf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sunf_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [W-1:0]             i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [W-1:0]             o_rd_data
);

    logic [W-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/sunf_front.sv -----
// Front end: line position, filter type and row tracking at the input beat.
// Depends on sunf_pkg.
`default_nettype none

module sunf_front
    import sunf_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MaxLineBytes
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire logic [ByteW-1:0]                  i_fbyte,
    input  wire logic                              i_soi,
    input  wire logic [LineW-1:0]                  i_line_bytes,
    output t_item                                  o_item,
    output logic      [$clog2(MAX_LINE_BYTES)-1:0] o_addr
);

    localparam int AW = $clog2(MAX_LINE_BYTES);
    localparam int LW = AW + 1;

    logic [AW-1:0]    r_pos;
    logic             r_await;
    logic             r_first;
    logic [ByteW-1:0] r_ftype;

    logic             await_eff;
    logic             first_eff;
    logic [AW-1:0]    pos_eff;
    logic [LW-1:0]    len_eff;
    logic [LW-1:0]    pos_inc;
    logic             eol;

    // Start of image restarts the row count and expects a type byte
    assign await_eff = i_soi | r_await;
    assign first_eff = i_soi | r_first;
    assign pos_eff   = i_soi ? '0 : r_pos;
    assign pos_inc   = {1'b0, pos_eff} + LW'(1);

    // Clamp the line length into 1..MAX_LINE_BYTES
    always_comb begin
        if (i_line_bytes == '0) begin
            len_eff = LW'(1);
        end else if (int'(i_line_bytes) > MAX_LINE_BYTES) begin
            len_eff = LW'(MAX_LINE_BYTES);
        end else begin
            len_eff = LW'(i_line_bytes);
        end
    end

    assign eol = (pos_inc >= len_eff);

    always_comb begin
        o_item.is_type   = await_eff;
        o_item.first_row = first_eff;
        o_item.eol       = eol;
        o_item.fbyte     = i_fbyte;
        o_item.ftype     = r_ftype;
    end

    assign o_addr = pos_eff;

    // Advance position and line state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_await <= 1'b1;
            r_first <= 1'b1;
            r_ftype <= FILT_NONE;
        end else if (i_accept) begin
            if (await_eff) begin
                r_ftype <= i_fbyte;
                r_await <= 1'b0;
                r_pos   <= '0;
                r_first <= first_eff;
            end else if (eol) begin
                r_pos   <= '0;
                r_await <= 1'b1;
                r_first <= 1'b0;
            end else begin
                r_pos   <= pos_inc[AW-1:0];
                r_first <= first_eff;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/sunf_recon.sv -----
// Reconstruction stage: neighbor histories, filter arithmetic, result register.
// Depends on sunf_pkg.
`default_nettype none

module sunf_recon
    import sunf_pkg::*;
#(
    parameter int MAX_LINE_BYTES  = MaxLineBytes,
    parameter int MAX_PIXEL_BYTES = MaxPixelBytes
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_accept,
    input  wire t_item                             i_item,
    input  wire logic [$clog2(MAX_LINE_BYTES)-1:0] i_addr,
    input  wire logic [ByteW-1:0]                  i_rd_data,
    input  wire logic [BppW-1:0]                   i_bpp,
    input  wire logic                              i_out_ready,
    output logic                                   o_ready,
    output logic                                   o_wr_en,
    output logic      [$clog2(MAX_LINE_BYTES)-1:0] o_wr_addr,
    output logic      [ByteW-1:0]                  o_wr_data,
    output logic                                   o_valid,
    output logic      [ByteW-1:0]                  o_pixel,
    output logic                                   o_eol,
    output logic                                   o_bad
);

    localparam int AW = $clog2(MAX_LINE_BYTES);
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [AW-1:0]    r_s1_addr;
    logic [ByteW-1:0] r_left  [MAX_PIXEL_BYTES];
    logic [ByteW-1:0] r_upper [MAX_PIXEL_BYTES];
    logic             r_out_valid;
    logic [ByteW-1:0] r_out_pixel;
    logic             r_out_eol;
    logic             r_out_bad;

    logic             s1_adv;
    logic             s1_data;
    logic [BppW-1:0]  bpp_m1;
    logic [PW-1:0]    tap;
    logic [ByteW-1:0] a;
    logic [ByteW-1:0] b;
    logic [ByteW-1:0] c;
    logic [ByteW:0]   ab_sum;
    logic [ByteW-1:0] result;
    logic             bad;

    // Type beats leave the stage at once; data beats wait for the result register
    assign s1_adv  = r_s1_valid & (r_s1_item.is_type | ~r_out_valid | i_out_ready);
    assign s1_data = s1_adv & ~r_s1_item.is_type;
    assign o_ready = ~r_s1_valid | s1_adv;

    // Left-neighbor distance, clamped into 1..MAX_PIXEL_BYTES
    always_comb begin
        if (i_bpp == '0) begin
            bpp_m1 = '0;
        end else if (int'(i_bpp) > MAX_PIXEL_BYTES) begin
            bpp_m1 = BppW'(MAX_PIXEL_BYTES - 1);
        end else begin
            bpp_m1 = i_bpp - BppW'(1);
        end
    end
    assign tap = bpp_m1[PW-1:0];

    // Neighbors: the first row sees zeros above
    assign a      = r_left[tap];
    assign b      = r_s1_item.first_row ? '0 : i_rd_data;
    assign c      = r_s1_item.first_row ? '0 : r_upper[tap];
    assign ab_sum = {1'b0, a} + {1'b0, b};

    // Filter arithmetic
    always_comb begin
        bad = 1'b0;
        case (r_s1_item.ftype)
            FILT_NONE:  result = r_s1_item.fbyte;
            FILT_SUB:   result = r_s1_item.fbyte + a;
            FILT_UP:    result = r_s1_item.fbyte + b;
            FILT_AVG:   result = r_s1_item.fbyte + ab_sum[ByteW:1];
            FILT_PAETH: result = r_s1_item.fbyte + paeth_pick(a, b, c);
            default: begin
                result = r_s1_item.fbyte;
                bad    = 1'b1;
            end
        endcase
    end

    // Write the reconstructed byte back for the next row
    assign o_wr_en   = s1_data;
    assign o_wr_addr = r_s1_addr;
    assign o_wr_data = result;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item <= i_item;
            r_s1_addr <= i_addr;
        end
    end

    // Histories: clear on a type beat, shift on a data beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                r_left[i]  <= '0;
                r_upper[i] <= '0;
            end
        end else if (s1_adv) begin
            if (r_s1_item.is_type) begin
                for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
                    r_left[i]  <= '0;
                    r_upper[i] <= '0;
                end
            end else begin
                for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                    r_left[i]  <= r_left[i-1];
                    r_upper[i] <= r_upper[i-1];
                end
                r_left[0]  <= result;
                r_upper[0] <= b;
            end
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_data) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (s1_data) begin
            r_out_pixel <= result;
            r_out_eol   <= r_s1_item.eol;
            r_out_bad   <= bad;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_eol   = r_out_eol;
    assign o_bad   = r_out_bad;

endmodule

`default_nettype wire

// ----- src/png_scanline_unfilter_unit.sv -----
// Scanline unfilter for filter method 0: byte stream in, raw image bytes out.
// The slave channel takes one decompressed byte per beat; tuser marks the
// first byte of an image. Each line opens with a filter-type byte, which
// gives no result, then line_bytes data bytes, each giving one output beat.
// The master channel carries the reconstructed byte, tlast on the last byte
// of a line and tuser set when the line's filter type is unknown (byte raw).
// A byte accepted passes the stage register and then the result register
// to the master side. Throughput: one byte per cycle unless the master side
// stalls; the loop that bounds it is the left-neighbor history, updated in
// the same cycle it is read. The prior row comes from a one-port-write,
// one-port-read line store whose read is issued as the byte is accepted.
// Reset clears all control state and histories; the line store is not
// cleared, and the first row of each image reads zeros above instead.
// A stall on the master side holds the result register and one more byte
// in the stage behind it; tready on the slave side drops only then.
// Configuration writes are taken at any time but must arrive while idle.
// Depends on sunf_pkg, sunf_ram, sunf_front and sunf_recon.
`default_nettype none

module png_scanline_unfilter_unit
    import sunf_pkg::*;
#(
    parameter int MAX_LINE_BYTES  = MaxLineBytes,
    parameter int MAX_PIXEL_BYTES = MaxPixelBytes
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // Configuration write channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [LineW-1:0] i_cfg_data,
    // Input stream
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [7:0]       i_s_axis_tdata,   // [7:0] filtered_byte
    input  wire logic [0:0]       i_s_axis_tuser,   // [0] start_of_image
    // Output stream
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic      [7:0]       o_m_axis_tdata,   // [7:0] pixel_byte
    output logic                  o_m_axis_tlast,
    output logic      [0:0]       o_m_axis_tuser    // [0] bad_filter
);

    localparam int AW = $clog2(MAX_LINE_BYTES);

    logic [BppW-1:0]  r_bpp;
    logic [LineW-1:0] r_line;

    logic             accept;
    logic             s1_ready;
    t_item            item;
    logic [AW-1:0]    addr;
    logic [ByteW-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ByteW-1:0] wr_data;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp  <= BppReset;
            r_line <= LineReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BYTES_PER_PIXEL: r_bpp  <= i_cfg_data[BppW-1:0];
                CFG_LINE_BYTES:      r_line <= i_cfg_data;
                default:             r_line <= r_line;
            endcase
        end
    end

    assign o_s_axis_tready = s1_ready;
    assign accept          = i_s_axis_tvalid & s1_ready;

    sunf_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_fbyte      (i_s_axis_tdata),
        .i_soi        (i_s_axis_tuser[0]),
        .i_line_bytes (r_line),
        .o_item       (item),
        .o_addr       (addr)
    );

    // Prior-row line store
    sunf_ram #(
        .W     (ByteW),
        .DEPTH (MAX_LINE_BYTES)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (addr),
        .o_rd_data (rd_data)
    );

    sunf_recon #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_recon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (item),
        .i_addr      (addr),
        .i_rd_data   (rd_data),
        .i_bpp       (r_bpp),
        .i_out_ready (i_m_axis_tready),
        .o_ready     (s1_ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_valid     (o_m_axis_tvalid),
        .o_pixel     (o_m_axis_tdata),
        .o_eol       (o_m_axis_tlast),
        .o_bad       (o_m_axis_tuser[0])
    );

endmodule

`default_nettype wire

// ----- src/sunf_checker.sv -----
// Port-level checks for the scanline unfilter, bound to the top level.
// Depends on png_scanline_unfilter_unit_assert.svh.
`default_nettype none

`include "png_scanline_unfilter_unit_assert.svh"

module sunf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_valid,
    input wire logic       o_cfg_ready,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast,
    input wire logic [0:0] o_m_axis_tuser
);

    // An empty result register never backs up the input
    `SUNF_ASSERT_NOW(a_ready_when_empty, !o_m_axis_tvalid, o_s_axis_tready)

    // A fresh result comes from a beat taken on the input and held in the stage register
    `SUNF_ASSERT_NOW(a_rise_has_source, $rose(o_m_axis_tvalid),
                     $past(i_s_axis_tvalid && o_s_axis_tready, 2))

    // A stalled result holds its beat
    `SUNF_ASSERT_NEXT(a_stall_holds, o_m_axis_tvalid && !i_m_axis_tready,
                      o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
                      $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))

    // The configuration channel never refuses a write
    `SUNF_ASSERT_NOW(a_cfg_always_ready, i_cfg_valid, o_cfg_ready)

endmodule

bind png_scanline_unfilter_unit sunf_checker u_sunf_checker (.*);

`default_nettype wire

// ----- sim/png_scanline_unfilter_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the scanline unfilter: streams filtered lines, writes
// the configuration between phases and checks every reconstructed byte.
// Depends on sunf_pkg and the unfilter top level.

module png_scanline_unfilter_unit_tb;
    import sunf_pkg::*;

    localparam int ClkPeriod   = 12;
    localparam int DrainCycles = 8;

    // One expected output beat
    typedef struct packed {
        logic [7:0] pixel;
        logic       eol;
        logic       bad;
    } t_pixel_beat;

    // Line reconstruction predictor plus the queue of bytes still owed by the block
    class t_unfilter_scoreboard;
        logic [7:0]       row_mem [MaxLineBytes];
        logic [7:0]       left_hist [8];
        logic [7:0]       upleft_hist [8];
        int unsigned      pos;
        logic [7:0]       line_type;
        bit               want_type;
        bit               first_row;
        logic [BppW-1:0]  bpp_reg;
        logic [LineW-1:0] len_reg;
        t_pixel_beat      pending_pixels [$];
        int unsigned      n_errors;

        function new();
            bpp_reg   = BppReset;
            len_reg   = LineReset;
            pos       = 0;
            line_type = FILT_NONE;
            want_type = 1'b1;
            first_row = 1'b1;
            n_errors  = 0;
            clear_history();
        endfunction

        function void clear_history();
            for (int i = 0; i < 8; i++) begin
                left_hist[i]   = 8'd0;
                upleft_hist[i] = 8'd0;
            end
        endfunction

        function void write_reg(logic [0:0] idx, logic [LineW-1:0] data);
            if (idx == CFG_BYTES_PER_PIXEL) begin
                bpp_reg = data[BppW-1:0];
            end else begin
                len_reg = data;
            end
        endfunction

        // Effective pixel width: zero acts as one, large values saturate
        function int unsigned pixel_width();
            if (bpp_reg == 0) return 1;
            if (bpp_reg > MaxPixelBytes) return MaxPixelBytes;
            return 32'(bpp_reg);
        endfunction

        // Effective line length, same clamping
        function int unsigned line_len();
            if (len_reg == 0) return 1;
            if (len_reg > MaxLineBytes) return MaxLineBytes;
            return 32'(len_reg);
        endfunction

        // Pick the neighbor closest to a + b - c, ties favor a, then b
        function logic [7:0] paeth_predict(logic [7:0] a, logic [7:0] b, logic [7:0] c);
            int p;
            int da;
            int db;
            int dc;
            p  = int'(a) + int'(b) - int'(c);
            da = p - int'(a);
            db = p - int'(b);
            dc = p - int'(c);
            if (da < 0) da = -da;
            if (db < 0) db = -db;
            if (dc < 0) dc = -dc;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // Advance the line state on one accepted input beat
        function void accept_stream_byte(logic [7:0] fb, logic soi);
            int unsigned width;
            int unsigned x;
            logic [7:0]  a;
            logic [7:0]  b;
            logic [7:0]  c;
            logic [7:0]  r;
            logic [8:0]  sum9;
            t_pixel_beat beat;
            if (soi) begin
                want_type = 1'b1;
                first_row = 1'b1;
                pos       = 0;
            end
            // The type byte opens a line and yields nothing
            if (want_type) begin
                line_type = fb;
                want_type = 1'b0;
                pos       = 0;
                clear_history();
                return;
            end
            width = pixel_width();
            x     = (pos >= MaxLineBytes) ? MaxLineBytes - 1 : pos;
            a     = left_hist[width-1];
            b     = first_row ? 8'd0 : row_mem[x];
            c     = first_row ? 8'd0 : upleft_hist[width-1];
            sum9  = {1'b0, a} + {1'b0, b};
            beat.bad = 1'b0;
            case (line_type)
                FILT_NONE:  r = fb;
                FILT_SUB:   r = fb + a;
                FILT_UP:    r = fb + b;
                FILT_AVG:   r = fb + sum9[8:1];
                FILT_PAETH: r = fb + paeth_predict(a, b, c);
                default: begin
                    r        = fb;
                    beat.bad = 1'b1;
                end
            endcase
            row_mem[x] = r;
            for (int i = 7; i > 0; i--) begin
                left_hist[i]   = left_hist[i-1];
                upleft_hist[i] = upleft_hist[i-1];
            end
            left_hist[0]   = r;
            upleft_hist[0] = b;
            beat.pixel = r;
            beat.eol   = (x + 1 >= line_len());
            if (beat.eol) begin
                pos       = 0;
                want_type = 1'b1;
                first_row = 1'b0;
            end else begin
                pos = x + 1;
            end
            pending_pixels.push_back(beat);
        endfunction

        // Compare one output beat against the oldest expected byte
        function void check_pixel(logic [7:0] pixel, logic eol, logic bad);
            t_pixel_beat want;
            if (pending_pixels.size() == 0) begin
                $error("unexpected output beat: pixel_byte %0h", pixel);
                n_errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (want.pixel !== pixel) begin
                $error("pixel_byte: expected %0h, actual %0h", want.pixel, pixel);
                n_errors++;
            end
            if (want.eol !== eol) begin
                $error("end_of_line: expected %0b, actual %0b", want.eol, eol);
                n_errors++;
            end
            if (want.bad !== bad) begin
                $error("bad_filter: expected %0b, actual %0b", want.bad, bad);
                n_errors++;
            end
        endfunction
    endclass

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_cfg_valid     = 1'b0;
    logic             o_cfg_ready;
    logic [0:0]       i_cfg_index     = CFG_BYTES_PER_PIXEL;
    logic [LineW-1:0] i_cfg_data      = '0;
    logic             i_s_axis_tvalid = 1'b0;
    logic             o_s_axis_tready;
    logic [7:0]       i_s_axis_tdata  = 8'd0;
    logic [0:0]       i_s_axis_tuser  = 1'b0;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready = 1'b0;
    logic [7:0]       o_m_axis_tdata;
    logic             o_m_axis_tlast;
    logic [0:0]       o_m_axis_tuser;

    t_unfilter_scoreboard sb = new();

    int          src_idle_pct  = 0;
    int          snk_stall_pct = 0;
    int unsigned hold_request  = 0;

    png_scanline_unfilter_unit dut (.*);

    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    // Hard limit on the whole run
    initial begin
        #(12_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Drive the output ready: random stalls, or a long hold-off when requested
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                i_m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Check every output beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_pixel(o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser[0]);
        end
    end

    // Offer one input beat after random idle cycles; hold tvalid until accepted
    task automatic send_byte(input logic [7:0] fb, input logic soi);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= fb;
        i_s_axis_tuser  <= soi;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.accept_stream_byte(fb, soi);
    endtask

    // Data byte, biased toward the extremes
    function automatic logic [7:0] filtered_value();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Mostly known filter types, now and then an unknown one
    function automatic logic [7:0] pick_filter();
        if ($urandom_range(99) < 10) return 8'($urandom_range(255, FILT_PAETH + 1));
        case ($urandom_range(4))
            0:       return FILT_NONE;
            1:       return FILT_SUB;
            2:       return FILT_UP;
            3:       return FILT_AVG;
            default: return FILT_PAETH;
        endcase
    endfunction

    task automatic send_line(input logic [7:0] ftype, input int unsigned n, input logic soi);
        send_byte(ftype, soi);
        repeat (n) send_byte(filtered_value(), 1'b0);
    endtask

    // Drop tvalid and wait for the block to drain
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [0:0] idx, input logic [LineW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // One random phase: configure, then mostly whole lines, some cut short by a new image
    task automatic run_phase(input int unsigned bpp, input int unsigned len, input int src,
                             input int snk, input int unsigned quota,
                             input int unsigned hold);
        int unsigned sent;
        int unsigned n;
        int unsigned cut;
        logic        soi;
        set_reg(CFG_BYTES_PER_PIXEL, {11'($urandom()), 4'(bpp)});
        set_reg(CFG_LINE_BYTES, LineW'(len));
        src_idle_pct  = src;
        snk_stall_pct = snk;
        hold_request  = hold;
        sent = 0;
        // open a new image so the row above is always one of this length
        soi  = 1'b1;
        while (sent < quota) begin
            n = sb.line_len();
            if ($urandom_range(99) < 12) begin
                cut = $urandom_range(n - 1, 0);
                send_line(pick_filter(), cut, soi);
                sent += cut + 1;
                soi = 1'b1;
            end else begin
                send_line(pick_filter(), n, soi);
                sent += n + 1;
                soi = ($urandom_range(99) < 8);
            end
        end
        settle();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: a first row with no filter, then each filter type with a row above, over byte extremes
        set_reg(CFG_BYTES_PER_PIXEL, LineW'(1));
        set_reg(CFG_LINE_BYTES, LineW'(3));
        send_line(FILT_NONE, 0, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0);
        send_line(FILT_SUB, 3, 1'b0);
        send_line(FILT_UP, 3, 1'b0);
        send_line(FILT_AVG, 3, 1'b0);
        send_line(FILT_PAETH, 3, 1'b0);
        send_line(8'hFF, 3, 1'b0);
        settle();

        // Shrink the line while in the middle of it: the next byte closes the line
        set_reg(CFG_LINE_BYTES, LineW'(6));
        send_line(FILT_PAETH, 4, 1'b1);
        settle();
        set_reg(CFG_LINE_BYTES, LineW'(2));
        send_byte(filtered_value(), 1'b0);
        send_line(FILT_AVG, 2, 1'b0);
        settle();

        // Random phases over widths, lengths and idle patterns
        run_phase(0, 0, 0, 0, 200, 0);
        run_phase(1, 9, 87, 0, 220, 0);
        run_phase(15, 40, 0, 87, 220, 0);
        run_phase(8, 1, 11, 11, 200, 0);
        run_phase(6, 13, 0, 0, 200, 300);
        run_phase(7, 24, 87, 0, 220, 0);
        run_phase(5, 6, 0, 87, 220, 0);
        run_phase(4, 17, 11, 11, 200, 0);

        if (sb.n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
